/* sv/srg_pkg.sv */
// Shared constants, types and helper functions for the subtractive random generator.
// No dependencies; used by srg_lag_table, subtractive_random_generator_unit and its bench.
`default_nettype none

package srg_pkg;

  localparam int unsigned TableDepth = 56;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned LastIdx    = TableDepth - 1;
  localparam int unsigned FillStep   = 21;
  localparam int unsigned MixLag     = 30;
  localparam int unsigned MixPasses  = 4;
  localparam int unsigned DivShift   = 31;

  localparam logic [31:0] Mbig  = 32'h7FFF_FFFF;
  localparam logic [31:0] Mseed = 32'd161803398;

  // action codes
  localparam logic ActReseed = 1'b0;
  localparam logic ActDraw   = 1'b1;

  typedef logic [IdxW-1:0] idx_t;

  typedef struct packed {
    logic        en;
    idx_t        addr;
    logic [31:0] data;
  } srg_wr_t;

  // x - y, optional MBIG pull-down, then fold negatives back by MBIG
  function automatic logic [31:0] sub_wrap(input logic [31:0] x, input logic [31:0] y,
                                           input logic dec_mbig);
    logic [31:0] r;
    r = x - y;
    if (dec_mbig && (r == Mbig)) begin
      r = r - 32'd1;
    end
    if (r[31]) begin
      r = r + Mbig;
    end
    return r;
  endfunction

  // step a rotating index over 1..TableDepth-1
  function automatic idx_t advance(input idx_t idx);
    idx_t n;
    n = idx + idx_t'(1);
    return (n >= idx_t'(TableDepth)) ? idx_t'(1) : n;
  endfunction

endpackage

`default_nettype wire

/* sv/srg_lag_table.sv */
// Lag table storage: one write port, two registered read ports.
// Per-entry valid flags make unwritten entries read as zero after reset.
// Depends on srg_pkg.
`default_nettype none

module srg_lag_table (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire srg_pkg::srg_wr_t wr_i,
  input  wire srg_pkg::idx_t   rd_addr_a_i,
  input  wire srg_pkg::idx_t   rd_addr_b_i,
  output logic [31:0]          rd_data_a_o,
  output logic [31:0]          rd_data_b_o
);

  logic [31:0]                     mem [srg_pkg::TableDepth];
  logic [srg_pkg::TableDepth-1:0]  valid_q;
  logic [31:0]                     rd_a_q, rd_b_q;
  logic                            va_q, vb_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_a_q <= mem[rd_addr_a_i];
    rd_b_q <= mem[rd_addr_b_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      va_q <= valid_q[rd_addr_a_i];
      vb_q <= valid_q[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = va_q ? rd_a_q : '0;
  assign rd_data_b_o = vb_q ? rd_b_q : '0;

endmodule

`default_nettype wire

/* sv/subtractive_random_generator_unit.sv */
// Subtractive random generator: after its input transfer a draw passes through subtract/write,
// multiply, constant divide and the output register; input ready returns with output valid.
// Reseed writes the seed entry, fills 54 entries, then mixes 4 passes x 55 entries, each entry
// a read and a write state on the shared subtract unit; a negative bound skips to the output.
// One item in flight; an unaccepted result at the output holds the next one in its last cycle.
// Async active-low reset: table reads as zero, lead 0, trail 21, no output. Uses srg_pkg.
`default_nettype none

module subtractive_random_generator_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               action_i,
  input  wire logic signed [31:0] seed_i,
  input  wire logic signed [31:0] max_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      sample_o,
  output logic signed [31:0]      scaled_value_o,
  output logic                    bad_bound_o
);

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StSeed    = 4'd1;
  localparam logic [3:0] StFill    = 4'd2;
  localparam logic [3:0] StMixRd   = 4'd3;
  localparam logic [3:0] StMixWr   = 4'd4;
  localparam logic [3:0] StDrawSub = 4'd5;
  localparam logic [3:0] StMul     = 4'd6;
  localparam logic [3:0] StDiv     = 4'd7;
  localparam logic [3:0] StOut     = 4'd8;

  logic [3:0]         state_q, state_d;
  srg_pkg::idx_t      lead_q, lead_d, trail_q, trail_d;
  logic [31:0]        seed_q, seed_d;
  logic [30:0]        maxv_q, maxv_d;
  logic [31:0]        mj_q, mj_d, mk_q, mk_d;
  srg_pkg::idx_t      pos_q, pos_d, cnt_q, cnt_d, mix_q, mix_d;
  logic [1:0]         pass_q, pass_d;
  logic [31:0]        samp_q, samp_d, quot_q, quot_d;
  logic [62:0]        prod_q, prod_d;
  logic               neg_q, neg_d, bad_q, bad_d;
  logic               out_valid_q, out_valid_d;
  logic [31:0]        out_sample_q, out_sample_d, out_scaled_q, out_scaled_d;
  logic               out_bad_q, out_bad_d;

  srg_pkg::srg_wr_t   wr;
  srg_pkg::idx_t      rd_addr_a, rd_addr_b, next_lead, next_trail, mix_j;
  logic [31:0]        rd_data_a, rd_data_b;
  logic [31:0]        su_x, su_y, su_r;
  logic               su_dec;
  logic [31:0]        mj_seed, seed_addend, mag;
  logic [6:0]         pos_sum;
  logic [62:0]        div_sum;
  logic               in_xfer, out_free;

  srg_lag_table u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b)
  );

  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign next_lead  = srg_pkg::advance(lead_q);
  assign next_trail = srg_pkg::advance(trail_q);
  // partner entry 1 + (i + 30) mod 55
  assign mix_j = (mix_q <= srg_pkg::idx_t'(srg_pkg::LastIdx - srg_pkg::MixLag - 1))
               ? mix_q + srg_pkg::idx_t'(srg_pkg::MixLag + 1)
               : mix_q - srg_pkg::idx_t'(srg_pkg::LastIdx - srg_pkg::MixLag - 1);

  assign rd_addr_a = (state_q == StMixRd) ? mix_q : next_lead;
  assign rd_addr_b = (state_q == StMixRd) ? mix_j : next_trail;

  // shared subtract-and-wrap unit
  always_comb begin
    su_x   = rd_data_a;
    su_y   = rd_data_b;
    su_dec = 1'b0;
    if (state_q == StFill) begin
      su_x = mj_q;
      su_y = mk_q;
    end else if (state_q == StDrawSub) begin
      su_dec = 1'b1;
    end
  end
  assign su_r = srg_pkg::sub_wrap(su_x, su_y, su_dec);

  // MSEED - |seed| as one add; most negative seed maps to MBIG
  assign seed_addend = seed_q[31] ? seed_q : ~seed_q;
  assign mj_seed = (seed_q == 32'h8000_0000) ? (srg_pkg::Mseed - srg_pkg::Mbig)
                 : srg_pkg::Mseed + seed_addend + {31'b0, !seed_q[31]};

  assign pos_sum = {1'b0, pos_q} + 7'(srg_pkg::FillStep);
  assign mag     = samp_q[31] ? (32'd0 - samp_q) : samp_q;
  // floor(x / (2^31-1)) = (x + (x >> 31) + 1) >> 31 for this product range
  assign div_sum = prod_q + (prod_q >> srg_pkg::DivShift) + 63'd1;

  always_comb begin
    state_d      = state_q;
    lead_d       = lead_q;
    trail_d      = trail_q;
    seed_d       = seed_q;
    maxv_d       = maxv_q;
    mj_d         = mj_q;
    mk_d         = mk_q;
    pos_d        = pos_q;
    cnt_d        = cnt_q;
    mix_d        = mix_q;
    pass_d       = pass_q;
    samp_d       = samp_q;
    quot_d       = quot_q;
    prod_d       = prod_q;
    neg_d        = neg_q;
    bad_d        = bad_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_sample_d = out_sample_q;
    out_scaled_d = out_scaled_q;
    out_bad_d    = out_bad_q;
    wr.en        = 1'b0;
    wr.addr      = mix_q;
    wr.data      = su_r;

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (action_i == srg_pkg::ActReseed) begin
            seed_d  = seed_i;
            state_d = StSeed;
          end else if (max_value_i[31]) begin
            samp_d  = '0;
            quot_d  = '0;
            neg_d   = 1'b0;
            bad_d   = 1'b1;
            state_d = StOut;
          end else begin
            maxv_d  = max_value_i[30:0];
            lead_d  = next_lead;
            trail_d = next_trail;
            bad_d   = 1'b0;
            state_d = StDrawSub;
          end
        end
      end
      StSeed: begin
        wr.en   = 1'b1;
        wr.addr = srg_pkg::idx_t'(srg_pkg::LastIdx);
        wr.data = mj_seed;
        mj_d    = mj_seed;
        mk_d    = 32'd1;
        pos_d   = srg_pkg::idx_t'(srg_pkg::FillStep);
        cnt_d   = srg_pkg::idx_t'(1);
        state_d = StFill;
      end
      StFill: begin
        wr.en   = 1'b1;
        wr.addr = pos_q;
        wr.data = mk_q;
        mk_d    = su_r;
        mj_d    = mk_q;
        pos_d   = (pos_sum >= 7'(srg_pkg::LastIdx))
                ? srg_pkg::idx_t'(pos_sum - 7'(srg_pkg::LastIdx))
                : pos_sum[srg_pkg::IdxW-1:0];
        cnt_d   = cnt_q + srg_pkg::idx_t'(1);
        if (cnt_q == srg_pkg::idx_t'(srg_pkg::LastIdx - 1)) begin
          mix_d   = srg_pkg::idx_t'(1);
          pass_d  = '0;
          state_d = StMixRd;
        end
      end
      StMixRd: begin
        state_d = StMixWr;
      end
      StMixWr: begin
        wr.en   = 1'b1;
        wr.addr = mix_q;
        if (mix_q == srg_pkg::idx_t'(srg_pkg::LastIdx)) begin
          mix_d = srg_pkg::idx_t'(1);
          if (pass_q == 2'(srg_pkg::MixPasses - 1)) begin
            lead_d  = '0;
            trail_d = srg_pkg::idx_t'(srg_pkg::FillStep);
            samp_d  = '0;
            quot_d  = '0;
            neg_d   = 1'b0;
            bad_d   = 1'b0;
            state_d = StOut;
          end else begin
            pass_d  = pass_q + 2'd1;
            state_d = StMixRd;
          end
        end else begin
          mix_d   = mix_q + srg_pkg::idx_t'(1);
          state_d = StMixRd;
        end
      end
      StDrawSub: begin
        wr.en   = 1'b1;
        wr.addr = lead_q;
        samp_d  = su_r;
        state_d = StMul;
      end
      StMul: begin
        prod_d  = mag * maxv_q;
        neg_d   = samp_q[31];
        state_d = StDiv;
      end
      StDiv: begin
        quot_d  = div_sum[62:31];
        state_d = StOut;
      end
      StOut: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_sample_d = samp_q;
          out_scaled_d = neg_q ? (32'd0 - quot_q) : quot_q;
          out_bad_d    = bad_q;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      lead_q      <= '0;
      trail_q     <= srg_pkg::idx_t'(srg_pkg::FillStep);
      cnt_q       <= '0;
      mix_q       <= '0;
      pass_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lead_q      <= lead_d;
      trail_q     <= trail_d;
      cnt_q       <= cnt_d;
      mix_q       <= mix_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seed_q       <= seed_d;
    maxv_q       <= maxv_d;
    mj_q         <= mj_d;
    mk_q         <= mk_d;
    pos_q        <= pos_d;
    samp_q       <= samp_d;
    quot_q       <= quot_d;
    prod_q       <= prod_d;
    neg_q        <= neg_d;
    bad_q        <= bad_d;
    out_sample_q <= out_sample_d;
    out_scaled_q <= out_scaled_d;
    out_bad_q    <= out_bad_d;
  end

  assign out_valid_o    = out_valid_q;
  assign sample_o       = out_sample_q;
  assign scaled_value_o = out_scaled_q;
  assign bad_bound_o    = out_bad_q;

endmodule

`default_nettype wire

/* bench/tb_subtractive_random_generator_unit.sv */
// Testbench for subtractive_random_generator_unit: directed and random reseed/draw items,
// each result checked against an in-bench model of the lag table and its two indices.
// Depends on srg_pkg and the RTL of the unit; self-contained otherwise.
module tb_subtractive_random_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] MostNeg = 32'h8000_0000;

  typedef struct {
    logic signed [31:0] sample;
    logic signed [31:0] scaled;
    logic               bad;
  } draw_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               action_i = 1'b0;
  logic signed [31:0] seed_i = '0;
  logic signed [31:0] max_value_i = '0;
  logic               out_ready_i = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic signed [31:0] sample_o;
  logic signed [31:0] scaled_value_o;
  logic               bad_bound_o;

  subtractive_random_generator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .seed_i        (seed_i),
    .max_value_i   (max_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sample_o      (sample_o),
    .scaled_value_o(scaled_value_o),
    .bad_bound_o   (bad_bound_o)
  );

  always #1 clk_i = ~clk_i;

  // model state
  logic [31:0] lag_tab [srg_pkg::TableDepth];
  logic [5:0]  lead_pos = 6'd0;
  logic [5:0]  trail_pos = 6'd21;

  draw_result_t owed_results[$];
  int unsigned  err_count = 0;
  bit           no_idle = 1'b0;
  int unsigned  stall_left = 0;

  initial begin
    foreach (lag_tab[i]) lag_tab[i] = '0;
  end

  function automatic logic [31:0] fold_neg(input logic [31:0] x);
    return x[31] ? x + srg_pkg::Mbig : x;
  endfunction

  function automatic logic [5:0] step_pos(input logic [5:0] p);
    logic [5:0] n;
    n = p + 6'd1;
    return (n >= 6'(srg_pkg::TableDepth)) ? 6'd1 : n;
  endfunction

  task automatic calc_reseed(input logic [31:0] seed);
    logic [31:0] mag, mj, mk;
    int unsigned pos;
    if (seed == MostNeg) mag = srg_pkg::Mbig;
    else mag = seed[31] ? -seed : seed;
    mj = srg_pkg::Mseed - mag;
    lag_tab[6'(srg_pkg::LastIdx)] = mj;
    mk = 32'd1;
    for (int unsigned i = 1; i < srg_pkg::LastIdx; i++) begin
      pos = (srg_pkg::FillStep * i) % srg_pkg::LastIdx;
      lag_tab[6'(pos)] = mk;
      mk = fold_neg(mj - mk);
      mj = lag_tab[6'(pos)];
    end
    for (int unsigned k = 0; k < srg_pkg::MixPasses; k++) begin
      for (int unsigned i = 1; i < srg_pkg::TableDepth; i++) begin
        lag_tab[6'(i)] = fold_neg(lag_tab[6'(i)]
                         - lag_tab[6'(1 + (i + srg_pkg::MixLag) % srg_pkg::LastIdx)]);
      end
    end
    lead_pos = 6'd0;
    trail_pos = 6'd21;
  endtask

  task automatic calc_draw(output logic [31:0] r);
    logic [5:0] a, b;
    a = step_pos(lead_pos);
    b = step_pos(trail_pos);
    r = lag_tab[a] - lag_tab[b];
    if (r == srg_pkg::Mbig) r = r - 32'd1;
    r = fold_neg(r);
    lag_tab[a] = r;
    lead_pos = a;
    trail_pos = b;
  endtask

  task automatic calc_outcome(input logic act, input logic [31:0] seed,
                              input logic signed [31:0] maxv);
    draw_result_t res;
    logic [31:0] s;
    longint prod;
    res.sample = '0;
    res.scaled = '0;
    res.bad = 1'b0;
    if (act == srg_pkg::ActReseed) begin
      calc_reseed(seed);
    end else if (maxv[31]) begin
      res.bad = 1'b1;
    end else begin
      calc_draw(s);
      prod = longint'($signed(s)) * longint'(maxv);
      res.sample = s;
      res.scaled = 32'(prod / 64'sd2147483647);
    end
    owed_results.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // mostly short idles, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result receiver: random back-pressure unless no_idle is set
  always @(posedge clk_i) begin
    if (no_idle) begin
      out_ready_i <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = pick_gap() - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // outputs are stable at the falling edge; the transfer follows at the next rising edge
  always @(negedge clk_i) begin
    draw_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (owed_results.size() == 0) begin
        report_mismatch("unexpected result", sample_o, '0);
      end else begin
        want = owed_results.pop_front();
        if (sample_o !== want.sample) report_mismatch("sample", sample_o, want.sample);
        if (scaled_value_o !== want.scaled)
          report_mismatch("scaled_value", scaled_value_o, want.scaled);
        if (bad_bound_o !== want.bad)
          report_mismatch("bad_bound", 32'(bad_bound_o), 32'(want.bad));
      end
    end
  end

  // valid is left high after the transfer; the next call lowers it or keeps it
  task automatic push_request(input logic act, input logic [31:0] seed,
                              input logic [31:0] maxv);
    int unsigned gap;
    gap = (no_idle || $urandom_range(0, 99) < 60) ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    seed_i <= seed;
    max_value_i <= maxv;
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
    end
    @(posedge clk_i);
    calc_outcome(act, seed, maxv);
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (owed_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 9))
      0: return MostNeg;
      1: return srg_pkg::Mbig;
      2: return 32'hFFFF_FFFF;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_bound();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 66) return $urandom & srg_pkg::Mbig;
    if (r < 78) return $urandom_range(0, 100);
    if (r < 88) return $urandom | MostNeg;
    if (r < 91) return srg_pkg::Mbig;
    if (r < 94) return '0;
    if (r < 96) return MostNeg;
    return $urandom;
  endfunction

  task automatic test_draw_from_reset();
    push_request(srg_pkg::ActDraw, $urandom, srg_pkg::Mbig);
    push_request(srg_pkg::ActDraw, $urandom, 32'd0);
    push_request(srg_pkg::ActDraw, $urandom, 32'hFFFF_FFFF);
    push_request(srg_pkg::ActDraw, $urandom, MostNeg);
  endtask

  task automatic test_seed_extremes();
    push_request(srg_pkg::ActReseed, 32'd0, $urandom);
    push_request(srg_pkg::ActDraw, 32'd0, srg_pkg::Mbig);
    push_request(srg_pkg::ActDraw, 32'd0, 32'd1);
    push_request(srg_pkg::ActReseed, MostNeg, $urandom);
    push_request(srg_pkg::ActDraw, MostNeg, srg_pkg::Mbig);
    push_request(srg_pkg::ActReseed, srg_pkg::Mbig, $urandom);
    push_request(srg_pkg::ActDraw, srg_pkg::Mbig, 32'd1000);
    push_request(srg_pkg::ActReseed, 32'hFFFF_FFFF, $urandom);
    push_request(srg_pkg::ActDraw, 32'hFFFF_FFFF, srg_pkg::Mbig);
    // seed equal to MSEED leaves the initial entry 55 at zero
    push_request(srg_pkg::ActReseed, srg_pkg::Mseed, $urandom);
    push_request(srg_pkg::ActDraw, srg_pkg::Mseed, srg_pkg::Mbig);
    push_request(srg_pkg::ActReseed, -srg_pkg::Mseed, $urandom);
    push_request(srg_pkg::ActDraw, $urandom, srg_pkg::Mbig);
  endtask

  task automatic test_bound_extremes();
    push_request(srg_pkg::ActDraw, $urandom, 32'd0);
    push_request(srg_pkg::ActDraw, $urandom, 32'd1);
    push_request(srg_pkg::ActDraw, $urandom, MostNeg);
    push_request(srg_pkg::ActDraw, $urandom, 32'hFFFF_FFFF);
    push_request(srg_pkg::ActDraw, $urandom, srg_pkg::Mbig);
    push_request(srg_pkg::ActDraw, $urandom, 32'h4000_0000);
  endtask

  task automatic test_random_stream(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 4) push_request(srg_pkg::ActReseed, pick_seed(), $urandom);
      else push_request(srg_pkg::ActDraw, $urandom, pick_bound());
    end
  endtask

  task automatic test_back_to_back(input int unsigned count);
    no_idle = 1'b1;
    test_random_stream(count);
    no_idle = 1'b0;
  endtask

  task automatic test_pause_after_drain(input int unsigned count);
    wait_results_drained();
    repeat ($urandom_range(1, 20)) @(posedge clk_i);
    test_random_stream(count);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_draw_from_reset();
    test_seed_extremes();
    test_bound_extremes();
    test_random_stream(650);
    test_back_to_back(200);
    test_pause_after_drain(180);
    wait_results_drained();
    repeat (20) @(posedge clk_i);
    if (owed_results.size() != 0)
      report_mismatch("results left over", 32'(owed_results.size()), 32'd0);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
